>>> rtl/fpg_pkg.sv
package fpg_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int TEMP_W = 19;
    localparam int TIME_W = 32;
    localparam int DELAY_W = 16;

    localparam logic [DELAY_W-1:0] INITIAL_BACKOFF_RST = 16'd5000;
    localparam logic [DELAY_W-1:0] MAX_BACKOFF_RST = 16'd60000;

    localparam logic [6:0] ADDR_PROFILE = 7'h54;
    localparam logic [6:0] ADDR_MODE = 7'h50;
    localparam logic [7:0] CTL_ON = 8'h11;
    localparam logic [7:0] CTL_SAFE = 8'h01;
    localparam logic [7:0] PB_SAFE = 8'h00;
    localparam logic [7:0] PB_NORMAL = 8'h32;
    localparam logic [7:0] PB_STARTUP = 8'hc8;

    localparam logic [2:0] PROFILE_NONE = 3'd5;
    localparam logic [2:0] PROFILE_STARTUP = 3'd0;
    localparam logic [2:0] PROFILE_FULL = 3'd4;

    typedef enum logic [1:0] {
        CMD_THERMAL = 2'd0,
        CMD_SAFE    = 2'd1,
        CMD_NORMAL  = 2'd2,
        CMD_STARTUP = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_WRITTEN   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_HELD      = 3'd2,
        ST_FAILED    = 3'd3,
        ST_NO_TELEM  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_BACKOFF = 1'b0,
        CFG_MAX_BACKOFF     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]               cmd;
        logic                     temp_valid;
        logic signed [TEMP_W-1:0] cpu_temp_mc;
        logic [TIME_W-1:0]        now_ms;
        logic                     bus_ok;
    } t_req;

    typedef struct packed {
        logic       write_issued;
        logic [6:0] bus_address;
        logic [7:0] control_byte;
        logic [7:0] profile_byte;
        logic [2:0] selected_profile;
        logic [2:0] status;
    } t_rsp;

    // duty byte of each thermal profile
    function automatic logic [7:0] band_byte(input logic [2:0] profile);
        logic [7:0] b;
        case (profile)
            3'd0:    b = 8'hc8;
            3'd1:    b = 8'he1;
            3'd2:    b = 8'he6;
            3'd3:    b = 8'heb;
            default: b = 8'hff;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/fpg_ifs.sv
interface fpg_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           cmd;
    logic                                 temp_valid;
    logic signed [fpg_pkg::TEMP_W-1:0]    cpu_temp_mc;
    logic [fpg_pkg::TIME_W-1:0]           now_ms;
    logic                                 bus_ok;

    modport source (output valid, cmd, temp_valid, cpu_temp_mc, now_ms, bus_ok,
                    input ready);
    modport sink (input valid, cmd, temp_valid, cpu_temp_mc, now_ms, bus_ok,
                  output ready);
endinterface

interface fpg_rsp_if;
    logic       valid;
    logic       ready;
    logic       write_issued;
    logic [6:0] bus_address;
    logic [7:0] control_byte;
    logic [7:0] profile_byte;
    logic [2:0] selected_profile;
    logic [2:0] status;

    modport source (output valid, write_issued, bus_address, control_byte,
                    profile_byte, selected_profile, status, input ready);
    modport sink (input valid, write_issued, bus_address, control_byte,
                  profile_byte, selected_profile, status, output ready);
endinterface

interface fpg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fpg_pkg::CFG_IDX_W-1:0]     index;
    logic [fpg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/fpg_band.sv
module fpg_band (
    input  logic signed [fpg_pkg::TEMP_W-1:0] i_temp_mc,
    output logic [2:0]                        o_profile
);
    import fpg_pkg::*;

    localparam logic signed [TEMP_W-1:0] T35 = 19'sd35000;
    localparam logic signed [TEMP_W-1:0] T40 = 19'sd40000;
    localparam logic signed [TEMP_W-1:0] T45 = 19'sd45000;
    localparam logic signed [TEMP_W-1:0] T50 = 19'sd50000;
    localparam logic signed [TEMP_W-1:0] T55 = 19'sd55000;

    // edges at 45 and 50 degrees fall through to full duty
    always_comb begin
        if (i_temp_mc >= T35 && i_temp_mc <= T40) begin
            o_profile = 3'd0;
        end else if (i_temp_mc > T40 && i_temp_mc < T45) begin
            o_profile = 3'd1;
        end else if (i_temp_mc > T45 && i_temp_mc < T50) begin
            o_profile = 3'd2;
        end else if (i_temp_mc > T50 && i_temp_mc < T55) begin
            o_profile = 3'd3;
        end else begin
            o_profile = PROFILE_FULL;
        end
    end
endmodule

>>> rtl/fpg_core.sv
module fpg_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  fpg_pkg::t_req                      i_req,
    input  logic                               i_cfg_we,
    input  logic [fpg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output fpg_pkg::t_rsp                      o_rsp
);
    import fpg_pkg::*;

    logic [DELAY_W-1:0]  r_initial_backoff;
    logic [DELAY_W-1:0]  r_max_backoff;
    logic [2:0]          r_last_profile;
    logic [TIME_W:0]     r_next_retry;
    logic [DELAY_W-1:0]  r_delay;

    logic [2:0]          n_last_profile;
    logic [TIME_W:0]     n_next_retry;
    logic [DELAY_W-1:0]  n_delay;

    logic [2:0]          band;
    logic                held;
    logic                want_write;
    logic                issue;
    logic [DELAY_W:0]    dbl;
    logic [DELAY_W-1:0]  capped;

    fpg_band u_band (
        .i_temp_mc (i_req.cpu_temp_mc),
        .o_profile (band)
    );

    assign held = {1'b0, i_req.now_ms} < r_next_retry;
    assign dbl = {r_delay, 1'b0};
    assign capped = (dbl < {1'b0, r_max_backoff}) ? dbl[DELAY_W-1:0] : r_max_backoff;

    always_comb begin
        o_rsp = '0;
        want_write = 1'b0;
        case (t_cmd'(i_req.cmd))
            CMD_THERMAL: begin
                if (!i_req.temp_valid) begin
                    o_rsp.status = ST_NO_TELEM;
                end else begin
                    o_rsp.selected_profile = band;
                    if (band == r_last_profile) begin
                        o_rsp.status = ST_UNCHANGED;
                    end else begin
                        want_write = 1'b1;
                        o_rsp.bus_address = ADDR_PROFILE;
                        o_rsp.control_byte = CTL_ON;
                        o_rsp.profile_byte = band_byte(band);
                    end
                end
            end
            CMD_SAFE: begin
                want_write = 1'b1;
                o_rsp.bus_address = ADDR_MODE;
                o_rsp.control_byte = CTL_SAFE;
                o_rsp.profile_byte = PB_SAFE;
            end
            CMD_NORMAL: begin
                want_write = 1'b1;
                o_rsp.bus_address = ADDR_MODE;
                o_rsp.control_byte = CTL_ON;
                o_rsp.profile_byte = PB_NORMAL;
            end
            default: begin
                want_write = 1'b1;
                o_rsp.bus_address = ADDR_PROFILE;
                o_rsp.control_byte = CTL_ON;
                o_rsp.profile_byte = PB_STARTUP;
            end
        endcase

        issue = want_write && !held;
        if (want_write) begin
            if (held) begin
                o_rsp.status = ST_HELD;
                o_rsp.bus_address = '0;
                o_rsp.control_byte = '0;
                o_rsp.profile_byte = '0;
            end else begin
                o_rsp.write_issued = 1'b1;
                o_rsp.status = i_req.bus_ok ? ST_WRITTEN : ST_FAILED;
            end
        end
    end

    always_comb begin
        n_last_profile = r_last_profile;
        n_next_retry = r_next_retry;
        n_delay = r_delay;
        if (issue) begin
            if (i_req.bus_ok) begin
                n_next_retry = '0;
                n_delay = r_initial_backoff;
                if (t_cmd'(i_req.cmd) == CMD_THERMAL) begin
                    n_last_profile = band;
                end else if (t_cmd'(i_req.cmd) == CMD_STARTUP) begin
                    n_last_profile = PROFILE_STARTUP;
                end
            end else begin
                n_next_retry = {1'b0, i_req.now_ms} + {{(TIME_W-DELAY_W+1){1'b0}}, r_delay};
                n_delay = capped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_backoff <= INITIAL_BACKOFF_RST;
            r_max_backoff <= MAX_BACKOFF_RST;
            r_last_profile <= PROFILE_NONE;
            r_next_retry <= '0;
            r_delay <= INITIAL_BACKOFF_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_INITIAL_BACKOFF: r_initial_backoff <= i_cfg_data;
                    CFG_MAX_BACKOFF:     r_max_backoff <= i_cfg_data;
                    default:             ;
                endcase
            end
            if (i_en) begin
                r_last_profile <= n_last_profile;
                r_next_retry <= n_next_retry;
                r_delay <= n_delay;
            end
        end
    end
endmodule

>>> rtl/fan_profile_governor_backoff.sv
// fan profile governor with bus-write backoff: each request word (thermal
// sample, safe mode, normal mode, startup) yields exactly one response word
// giving the payload that would go on the bus and a status code. a request is
// registered on entry, decided in one pass against the retry timer, delay and
// last written profile, and the response is registered on exit, so one
// request is taken every cycle while the response side is not stalled. the
// response word is offered once its request has passed through the request
// register and the response register; a stalled response holds the request
// register, which then holds off the next request. the user must see that
// the two backoff registers are written through the config port while the
// block is idle; the block itself does not enforce this
module fan_profile_governor_backoff (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fpg_req_if.sink      i_req,
    fpg_rsp_if.source    o_rsp,
    fpg_cfg_if.sink      i_cfg
);
    import fpg_pkg::*;

    // input stage
    t_req  r_req;
    logic  r_req_valid;

    // output stage
    t_rsp  r_rsp;
    logic  r_rsp_valid;

    t_rsp  core_rsp;
    logic  advance;
    logic  req_accept;

    // the decide step fires when the output register is free or draining
    assign advance = r_req_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = !r_req_valid || advance;
    assign req_accept = i_req.valid && i_req.ready;

    // config words are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req.cmd <= i_req.cmd;
            r_req.temp_valid <= i_req.temp_valid;
            r_req.cpu_temp_mc <= i_req.cpu_temp_mc;
            r_req.now_ms <= i_req.now_ms;
            r_req.bus_ok <= i_req.bus_ok;
        end
        if (advance) begin
            r_rsp <= core_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (req_accept) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end
            if (advance) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // decision logic and backoff state
    fpg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_req       (r_req),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_rsp       (core_rsp)
    );

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.write_issued = r_rsp.write_issued;
    assign o_rsp.bus_address = r_rsp.bus_address;
    assign o_rsp.control_byte = r_rsp.control_byte;
    assign o_rsp.profile_byte = r_rsp.profile_byte;
    assign o_rsp.selected_profile = r_rsp.selected_profile;
    assign o_rsp.status = r_rsp.status;
endmodule

>>> rtl/fpg_checker.sv
module fpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_write_issued,
    input logic [6:0] i_bus_address,
    input logic [7:0] i_control_byte,
    input logic [7:0] i_profile_byte,
    input logic [2:0] i_status
);
    import fpg_pkg::*;

    // no response word straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // a stalled response word stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // an attempted write always carries a known target and control byte
    a_payload_when_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_write_issued |->
            (i_bus_address == ADDR_PROFILE || i_bus_address == ADDR_MODE) &&
            (i_control_byte == CTL_ON || i_control_byte == CTL_SAFE))
        else $error("bad payload on issued write");

    // no payload without a write
    a_payload_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_write_issued |->
            i_bus_address == '0 && i_control_byte == '0 && i_profile_byte == '0)
        else $error("payload present without a write");

    // written and failed go with an attempt, the other codes without
    a_status_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            (i_write_issued == (i_status == ST_WRITTEN || i_status == ST_FAILED)))
        else $error("status disagrees with write flag");
endmodule

bind fan_profile_governor_backoff fpg_checker u_fpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_write_issued (o_rsp.write_issued),
    .i_bus_address  (o_rsp.bus_address),
    .i_control_byte (o_rsp.control_byte),
    .i_profile_byte (o_rsp.profile_byte),
    .i_status       (o_rsp.status)
);
